>>> src/stip_pkg.sv
package stip_pkg;

  localparam int DATA_W  = 32;
  localparam int INDEX_W = 10;
  localparam int COUNT_W = 11;
  localparam int CFG_IDX_W = 1;
  localparam int ADDR_WIDE_W = 17;

  localparam logic [DATA_W-1:0] SIGN_FLIP = 32'h8000_0000;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENTRY_COUNT   = 1'b0,
    REG_STOP_ON_MATCH = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_SEARCH = 1'b1
  } state_t;

  // queued item, already classified; data is the order key (value ^ sign bit)
  typedef struct packed {
    op_t               op;
    logic              wr_ok;
    logic [INDEX_W-1:0] index;
    logic [DATA_W-1:0]  data;
  } item_t;

endpackage

>>> src/stip_ram.sv
module stip_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/stip_front.sv
module stip_front #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                opcode,
  input  logic [stip_pkg::INDEX_W-1:0]        entry_index,
  input  logic signed [stip_pkg::DATA_W-1:0]  entry_value,
  input  logic signed [stip_pkg::DATA_W-1:0]  target,
  output logic                                head_valid,
  output stip_pkg::item_t                     head,
  input  logic                                pop
);
  import stip_pkg::*;

  localparam int QDEPTH = 2;
  localparam int QAW = 1;

  item_t            q [QDEPTH];
  logic [QAW-1:0]   wr_ptr;
  logic [QAW-1:0]   rd_ptr;
  logic [QAW:0]     count;
  logic             push;
  item_t            cls;

  assign in_stall   = (count == (QAW+1)'(QDEPTH));
  assign push       = in_valid && !in_stall;
  assign head_valid = (count != '0);
  assign head       = q[rd_ptr];

  always_comb begin
    cls.op    = op_t'(opcode);
    cls.wr_ok = (ADDR_WIDE_W'(entry_index) < ADDR_WIDE_W'(TABLE_DEPTH));
    cls.index = entry_index;
    cls.data  = (opcode ? target : entry_value) ^ SIGN_FLIP;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (QAW+1)'(push) - (QAW+1)'(pop);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (QAW+1)'(QDEPTH))
    else $error("queue count past depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("pop from empty queue");

endmodule

>>> src/stip_back.sv
module stip_back #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [stip_pkg::COUNT_W-1:0]        entry_count,
  input  logic                                stop_on_match,
  input  logic                                head_valid,
  input  stip_pkg::item_t                     head,
  output logic                                pop,
  output logic                                ram_we,
  output logic [(TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1)-1:0] ram_waddr,
  output logic [stip_pkg::DATA_W-1:0]         ram_wdata,
  output logic [(TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1)-1:0] ram_raddr,
  input  logic [stip_pkg::DATA_W-1:0]         ram_rdata,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [stip_pkg::COUNT_W-1:0]        insert_point
);
  import stip_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  state_t              state;
  state_t              state_next;
  logic [COUNT_W-1:0]  lo;
  logic [COUNT_W-1:0]  lo_next;
  logic [COUNT_W-1:0]  hi;
  logic [COUNT_W-1:0]  hi_next;
  logic [COUNT_W-1:0]  m;
  logic [COUNT_W-1:0]  m_next;
  logic [DATA_W-1:0]   key;
  logic [DATA_W-1:0]   key_next;
  logic [COUNT_W-1:0]  n_sat;
  logic [COUNT_W-1:0]  lo_c;
  logic [COUNT_W-1:0]  hi_c;
  logic [COUNT_W-1:0]  probe;
  logic [COUNT_W-1:0]  res_val;
  logic                res_load;
  logic                out_free;
  logic [ADDR_WIDE_W-1:0] probe_wide;
  logic [ADDR_WIDE_W-1:0] widx_wide;

  assign n_sat = (ADDR_WIDE_W'(entry_count) > ADDR_WIDE_W'(TABLE_DEPTH))
               ? COUNT_W'(TABLE_DEPTH) : entry_count;
  assign out_free = !out_valid || !out_stall;

  assign probe_wide = ADDR_WIDE_W'(probe);
  assign widx_wide  = ADDR_WIDE_W'(head.index);
  assign ram_raddr  = probe_wide[AW-1:0];
  assign ram_waddr  = widx_wide[AW-1:0];
  assign ram_wdata  = head.data;

  always_comb begin
    state_next = state;
    lo_next    = lo;
    hi_next    = hi;
    m_next     = m;
    key_next   = key;
    pop        = 1'b0;
    ram_we     = 1'b0;
    res_load   = 1'b0;
    res_val    = '0;
    lo_c       = lo;
    hi_c       = hi;
    probe      = m;
    unique case (state)
      ST_IDLE: begin
        if (head_valid) begin
          if (head.op == OP_WRITE) begin
            pop    = 1'b1;
            ram_we = head.wr_ok;
          end else if (out_free) begin
            pop      = 1'b1;
            key_next = head.data;
            if (n_sat == '0) begin
              res_load = 1'b1;
            end else begin
              lo_next    = '0;
              hi_next    = n_sat;
              m_next     = (n_sat - 1'b1) >> 1;
              probe      = m_next;
              state_next = ST_SEARCH;
            end
          end
        end
      end
      ST_SEARCH: begin
        if (ram_rdata < key) begin
          lo_c = m + 1'b1;
        end else begin
          hi_c = m;
        end
        if (ram_rdata == key && stop_on_match) begin
          res_load   = 1'b1;
          res_val    = m;
          state_next = ST_IDLE;
        end else if (lo_c < hi_c) begin
          lo_next = lo_c;
          hi_next = hi_c;
          m_next  = lo_c + ((hi_c - lo_c - 1'b1) >> 1);
          probe   = m_next;
        end else begin
          res_load   = 1'b1;
          res_val    = lo_c;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    lo  <= lo_next;
    hi  <= hi_next;
    m   <= m_next;
    key <= key_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      insert_point <= res_val;
    end
  end

  a_probe_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEARCH) |-> (m >= lo && m < hi))
    else $error("probe outside search interval");

  a_out_empty_in_search: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEARCH) |-> !out_valid)
    else $error("result slot busy during search");

  a_no_write_in_search: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEARCH) |-> !ram_we && !pop)
    else $error("table write or pop during search");

  a_result_bound: assert property (@(posedge clk) disable iff (rst)
    res_load |-> (res_val <= n_sat))
    else $error("insertion point past covered count");

endmodule

>>> src/sorted_table_insertion_point_core.sv
// Sorted table with binary-search insertion point. Write items (opcode 0)
// load one signed 32-bit entry each; writes at an index not below TABLE_DEPTH
// are dropped. Query items (opcode 1) return the lower bound of target over
// the first entry_count entries (capped at TABLE_DEPTH), or with
// stop_on_match set, the first probed midpoint equal to target. Entries are
// undefined until written and are not cleared by reset; a query must only
// touch written entries. Items pass through a two-entry queue into a search
// engine that owns one RAM read port. A write is popped and written to the
// RAM in the same cycle that it reaches the idle engine. A query has an issue
// step and then one step per probe (no probe when n covered entries is 0):
// each probe is a registered RAM read whose data selects the next address in
// the same cycle. Configuration is to be written only while the block is idle.
module sorted_table_insertion_point_core #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                opcode,
  input  logic [stip_pkg::INDEX_W-1:0]        entry_index,
  input  logic signed [stip_pkg::DATA_W-1:0]  entry_value,
  input  logic signed [stip_pkg::DATA_W-1:0]  target,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [stip_pkg::COUNT_W-1:0]        insert_point,
  input  logic                                cfg_wr_en,
  input  logic [stip_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [stip_pkg::COUNT_W-1:0]        cfg_data
);
  import stip_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic [COUNT_W-1:0] entry_count;
  logic               stop_on_match;
  logic               head_valid;
  item_t              head;
  logic               pop;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [AW-1:0]      ram_raddr;
  logic [DATA_W-1:0]  ram_wdata;
  logic [DATA_W-1:0]  ram_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count   <= '0;
      stop_on_match <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ENTRY_COUNT:   entry_count   <= cfg_data;
        REG_STOP_ON_MATCH: stop_on_match <= cfg_data[0];
        default: ;
      endcase
    end
  end

  stip_front #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .opcode      (opcode),
    .entry_index (entry_index),
    .entry_value (entry_value),
    .target      (target),
    .head_valid  (head_valid),
    .head        (head),
    .pop         (pop)
  );

  stip_ram #(
    .WIDTH (DATA_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  stip_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .entry_count   (entry_count),
    .stop_on_match (stop_on_match),
    .head_valid    (head_valid),
    .head          (head),
    .pop           (pop),
    .ram_we        (ram_we),
    .ram_waddr     (ram_waddr),
    .ram_wdata     (ram_wdata),
    .ram_raddr     (ram_raddr),
    .ram_rdata     (ram_rdata),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .insert_point  (insert_point)
  );

endmodule

>>> tb/stip_tb_pkg.sv
package stip_tb_pkg;
  import stip_pkg::*;

  localparam int TABLE_DEPTH = 1024;

  class insert_point_checker;
    logic signed [DATA_W-1:0] entries [TABLE_DEPTH];
    logic [COUNT_W-1:0] entry_count;
    logic stop_on_match;
    logic [COUNT_W-1:0] expected_points [$];
    int errors;

    function new();
      entry_count = '0;
      stop_on_match = 1'b0;
      errors = 0;
    endfunction

    function void set_register(cfg_reg_t idx, logic [COUNT_W-1:0] data);
      case (idx)
        REG_ENTRY_COUNT: entry_count = data;
        REG_STOP_ON_MATCH: stop_on_match = data[0];
        default: ;
      endcase
    endfunction

    // half-open interval search: lower bound, or first equal probe when enabled
    function logic [COUNT_W-1:0] locate(logic signed [DATA_W-1:0] key);
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      lo = 0;
      hi = (entry_count > TABLE_DEPTH) ? TABLE_DEPTH : entry_count;
      while (lo < hi) begin
        mid = lo + (hi - 1 - lo) / 2;
        if (entries[mid] < key) begin
          lo = mid + 1;
        end else if (entries[mid] > key) begin
          hi = mid;
        end else begin
          if (stop_on_match) return COUNT_W'(mid);
          hi = mid;
        end
      end
      return COUNT_W'(lo);
    endfunction

    function void note_item(op_t op, logic [INDEX_W-1:0] idx,
                            logic signed [DATA_W-1:0] value,
                            logic signed [DATA_W-1:0] tgt);
      if (op == OP_WRITE) begin
        if (idx < TABLE_DEPTH) entries[idx] = value;
      end else begin
        expected_points.push_back(locate(tgt));
      end
    endfunction

    function void check_point(logic [COUNT_W-1:0] got);
      logic [COUNT_W-1:0] want;
      if (expected_points.size() == 0) begin
        $error("insert_point: expected none, actual %0d", got);
        errors++;
      end else begin
        want = expected_points.pop_front();
        if (got !== want) begin
          $error("insert_point: expected %0d, actual %0d", want, got);
          errors++;
        end
      end
    endfunction
  endclass

endpackage

>>> tb/tb_top.sv
module tb_top;
  import stip_pkg::*;
  import stip_tb_pkg::*;

  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;
  localparam int DRAIN_GAP = 24;
  localparam int HOLD_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT = 600000;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic opcode;
  logic [INDEX_W-1:0] entry_index;
  logic signed [DATA_W-1:0] entry_value;
  logic signed [DATA_W-1:0] target;
  logic out_valid;
  logic out_stall;
  logic [COUNT_W-1:0] insert_point;
  logic cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COUNT_W-1:0] cfg_data;

  insert_point_checker sb;
  int send_idle_pct;
  int recv_stall_pct;
  bit hold_req;
  int hold_left;
  int items_sent;
  int filled;
  int unsigned cycle_count = 0;

  sorted_table_insertion_point_core #(.TABLE_DEPTH(TABLE_DEPTH)) u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .opcode(opcode),
    .entry_index(entry_index),
    .entry_value(entry_value),
    .target(target),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .insert_point(insert_point),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall)
      sb.note_item(op_t'(opcode), entry_index, entry_value, target);
    if (!rst && out_valid && !out_stall)
      sb.check_point(insert_point);
  end

  // result side: random stalls plus a long hold-off when requested
  initial begin
    out_stall <= 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  task automatic send_item(op_t op, logic [INDEX_W-1:0] idx,
                           logic signed [DATA_W-1:0] value,
                           logic signed [DATA_W-1:0] tgt);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    entry_index <= idx;
    entry_value <= value;
    target <= tgt;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic send_write(int idx, logic signed [DATA_W-1:0] value);
    send_item(OP_WRITE, INDEX_W'(idx), value, $urandom);
  endtask

  task automatic send_query(logic signed [DATA_W-1:0] tgt);
    send_item(OP_QUERY, INDEX_W'($urandom), $urandom, tgt);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_points.size() != 0) @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  task automatic load_config(logic [COUNT_W-1:0] count, logic stop);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_ENTRY_COUNT;
    cfg_data <= count;
    sb.set_register(REG_ENTRY_COUNT, count);
    @(posedge clk);
    cfg_index <= REG_STOP_ON_MATCH;
    cfg_data <= COUNT_W'(stop);
    sb.set_register(REG_STOP_ON_MATCH, COUNT_W'(stop));
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // mostly hits and near misses on stored values
  function automatic logic signed [DATA_W-1:0] pick_target();
    int n;
    int k;
    logic signed [DATA_W-1:0] v;
    n = (sb.entry_count > TABLE_DEPTH) ? TABLE_DEPTH : sb.entry_count;
    k = $urandom_range(0, 9);
    if (k == 9) return $urandom_range(0, 1) ? VAL_MIN : VAL_MAX;
    if (n == 0 || k == 8) return $urandom;
    v = sb.entries[$urandom_range(0, n - 1)];
    if (k < 4) return v;
    if (k < 6) return v - 1;
    return v + 1;
  endfunction

  task automatic query_burst(int nq);
    repeat (nq) send_query(pick_target());
  endtask

  // strictly increasing values, well inside the signed range
  function automatic logic signed [DATA_W-1:0] spine_value(int idx);
    return DATA_W'(idx * 4096 - 2000000);
  endfunction

  // entries on the leftmost and rightmost probe paths of a full-table search
  task automatic load_spine();
    int idx;
    for (int k = 0; k < 10; k++) begin
      idx = (1 << k) - 1;
      send_write(idx, spine_value(idx));
      idx = TABLE_DEPTH - 1 - (1 << k);
      send_write(idx, spine_value(idx));
    end
    send_write(TABLE_DEPTH - 1, spine_value(TABLE_DEPTH - 1));
  endtask

  // targets whose searches stay on the loaded paths
  task automatic spine_queries();
    send_query(VAL_MIN);
    send_query(VAL_MAX);
    send_query(spine_value(0));
    send_query(spine_value(TABLE_DEPTH - 1));
    if (sb.stop_on_match) send_query(spine_value(TABLE_DEPTH / 2 - 1));
  endtask

  task automatic run_set(int min_n, int max_n);
    int n;
    int cnt;
    int unsigned spread;
    bit unsorted;
    logic signed [DATA_W-1:0] r;
    longint cur;
    n = $urandom_range(min_n, max_n);
    unsorted = ($urandom_range(0, 5) == 0);
    case ($urandom_range(0, 3))
      0: spread = 2;
      1: spread = 20;
      2: spread = 1 << 16;
      default: spread = 1 << 26;
    endcase
    r = $urandom;
    cur = r;
    for (int i = 0; i < n; i++) begin
      if (unsorted) begin
        send_write(i, $urandom);
      end else begin
        send_write(i, cur[DATA_W-1:0]);
        cur += $urandom_range(0, spread);
        if (cur > longint'(VAL_MAX)) cur = VAL_MAX;
      end
    end
    if (n > filled) filled = n;
    drain();
    cnt = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n) : n;
    load_config(COUNT_W'(cnt), 1'($urandom_range(0, 1)));
    query_burst($urandom_range(1, 12));
    if (filled > 0 && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) send_write($urandom_range(0, filled - 1), $urandom);
      query_burst(3);
    end
  endtask

  initial begin
    sb = new();
    send_idle_pct = 12;
    recv_stall_pct = 58;
    hold_req = 1'b0;
    items_sent = 0;
    filled = 0;
    rst <= 1'b1;
    in_valid <= 1'b0;
    opcode <= OP_WRITE;
    entry_index <= '0;
    entry_value <= '0;
    target <= '0;
    cfg_wr_en <= 1'b0;
    cfg_index <= REG_ENTRY_COUNT;
    cfg_data <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty table after reset, then a small table with duplicates and extremes
    send_query(VAL_MIN);
    send_query(VAL_MAX);
    send_write(0, VAL_MIN);
    send_write(1, -1);
    send_write(2, 3);
    send_write(3, 3);
    send_write(4, 3);
    send_write(5, 3);
    send_write(6, VAL_MAX);
    send_write(1023, 0);
    filled = 7;
    drain();
    load_config(COUNT_W'(7), 1'b0);
    send_query(VAL_MIN);
    send_query(VAL_MAX);
    send_query(3);
    send_query(4);
    send_query(-2);
    send_query(0);
    drain();
    load_config(COUNT_W'(7), 1'b1);
    send_query(3);
    send_query(VAL_MAX);
    send_query(VAL_MIN);

    // long result hold-off while items keep coming: block fills and stalls
    send_idle_pct = 12;
    recv_stall_pct = 58;
    hold_req = 1'b1;
    query_burst(16);
    drain();

    while (items_sent < 260) run_set(0, ($urandom_range(0, 7) == 0) ? 100 : 20);
    send_idle_pct = 58;
    recv_stall_pct = 12;
    while (items_sent < 480) run_set(0, ($urandom_range(0, 7) == 0) ? 100 : 20);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    while (items_sent < 660) run_set(0, ($urandom_range(0, 7) == 0) ? 100 : 20);

    // counts at and beyond the table size over the outer probe paths
    load_spine();
    drain();
    load_config(COUNT_W'(TABLE_DEPTH), 1'($urandom_range(0, 1)));
    spine_queries();
    drain();
    load_config('1, 1'($urandom_range(0, 1)));
    spine_queries();
    drain();
    load_config(COUNT_W'($urandom_range(TABLE_DEPTH + 1, 2047)), 1'($urandom_range(0, 1)));
    spine_queries();

    drain();
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
